### sv/tea_block_encrypt_macros.svh
// Assertion macros for the TEA block encryption design.
// Used by tea_key_regs and tea_block_encrypt; needs clk and rst_n in scope.
`ifndef TEA_BLOCK_ENCRYPT_MACROS_SVH
`define TEA_BLOCK_ENCRYPT_MACROS_SVH

// same-cycle implication
`define TEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tea_pkg.sv
// Shared types, constants and round-sum function for the TEA encryptor.
// No dependencies; used by all modules of tea_block_encrypt.
package tea_pkg;

  typedef logic [31:0] word_t;

  localparam int ROUND_COUNT = 32;
  localparam int STAGE_COUNT = 2 * ROUND_COUNT;  // one half-round per stage
  localparam int CFG_IDX_W   = 8;

  localparam word_t TEA_DELTA = 32'h9E37_79B9;

  localparam word_t KEY0_RST = 32'h7384_ABD7;
  localparam word_t KEY1_RST = 32'hC8DD_91A5;
  localparam word_t KEY2_RST = 32'hF24D_1234;
  localparam word_t KEY3_RST = 32'h3EFE_2A10;

  localparam logic [CFG_IDX_W-1:0] KEY_IDX_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_3 = 8'd3;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_set_t;

  // fixed per-stage control, tied off at elaboration
  typedef struct packed {
    logic  second;  // 1: update right word, 0: update left word
    word_t total;   // running delta sum of this round
  } stage_ctl_t;

  // delta sum for round r (0-based): (r + 1) * delta mod 2^32
  function automatic word_t round_total(input int r);
    logic [63:0] prod;
    prod = 64'(r + 1) * 64'(TEA_DELTA);
    return prod[31:0];
  endfunction

endpackage

### sv/tea_key_regs.sv
// Key register file for the TEA encryptor: four 32-bit words, write-only port.
// Depends on tea_pkg and tea_block_encrypt_macros.svh.
`include "tea_block_encrypt_macros.svh"

module tea_key_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  tea_pkg::word_t                cfg_data,
  output tea_pkg::key_set_t             keys
);

  tea_pkg::key_set_t keys_r, keys_nxt;

  always_comb begin
    keys_nxt = keys_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tea_pkg::KEY_IDX_0: keys_nxt.k0 = cfg_data;
        tea_pkg::KEY_IDX_1: keys_nxt.k1 = cfg_data;
        tea_pkg::KEY_IDX_2: keys_nxt.k2 = cfg_data;
        tea_pkg::KEY_IDX_3: keys_nxt.k3 = cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '{k0: tea_pkg::KEY0_RST, k1: tea_pkg::KEY1_RST,
                  k2: tea_pkg::KEY2_RST, k3: tea_pkg::KEY3_RST};
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;

  `TEA_ASSERT_NEXT(a_key0_write, cfg_valid && (cfg_index == tea_pkg::KEY_IDX_0),
                   keys_r.k0 == $past(cfg_data), "key word 0 write lost")

endmodule

### sv/tea_stage.sv
// One TEA half-round with its pipeline register and valid bit.
// Depends on tea_pkg.
module tea_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  tea_pkg::stage_ctl_t ctl,
  input  tea_pkg::key_set_t   keys,
  input  logic                vld_in,
  input  tea_pkg::word_t      left_in,
  input  tea_pkg::word_t      right_in,
  output logic                vld_out,
  output tea_pkg::word_t      left_out,
  output tea_pkg::word_t      right_out
);

  function automatic tea_pkg::word_t mix(input tea_pkg::word_t v,
                                         input tea_pkg::word_t total,
                                         input tea_pkg::word_t ka,
                                         input tea_pkg::word_t kb);
    return ((v << 4) + ka) ^ (v + total) ^ ((v >> 5) + kb);
  endfunction

  logic           vld_r;
  tea_pkg::word_t left_r, right_r;
  tea_pkg::word_t left_nxt, right_nxt;

  always_comb begin
    left_nxt  = left_in;
    right_nxt = right_in;
    if (ctl.second) begin
      right_nxt = right_in + mix(left_in, ctl.total, keys.k2, keys.k3);
    end else begin
      left_nxt = left_in + mix(right_in, ctl.total, keys.k0, keys.k1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign left_out  = left_r;
  assign right_out = right_r;

endmodule

### sv/tea_block_encrypt.sv
// Top level of the TEA block encryptor: key registers and the half-round pipeline.
// Depends on tea_pkg, tea_key_regs, tea_stage and tea_block_encrypt_macros.svh.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_left_word, in_right_word
//   out      output     out_valid / out_ready out_cipher_left, out_cipher_right
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One registered stage per half-round, the last stage being the output register.
// One item per cycle sustained while out_ready stays high.
// The whole pipeline advances when the output register is empty or taken,
// so a waiting result stalls intake even while earlier stages hold bubbles.
// A stall freezes every stage; nothing is lost or repeated.
// rst_n is synchronous: valid bits clear and the key words take their defaults.
`include "tea_block_encrypt_macros.svh"

module tea_block_encrypt (
  input  logic                          clk,
  input  logic                          rst_n,
  // plaintext items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tea_pkg::word_t                in_left_word,
  input  tea_pkg::word_t                in_right_word,
  // cipher items
  output logic                          out_valid,
  input  logic                          out_ready,
  output tea_pkg::word_t                out_cipher_left,
  output tea_pkg::word_t                out_cipher_right,
  // key writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  tea_pkg::word_t                cfg_data
);

  localparam int N = tea_pkg::STAGE_COUNT;

  tea_pkg::key_set_t keys;
  logic              adv;

  // slot 0 is the input port, slot N the output register
  logic              vld_a   [N+1];
  tea_pkg::word_t    left_a  [N+1];
  tea_pkg::word_t    right_a [N+1];

  // key writes are always taken
  assign cfg_ready = 1'b1;

  tea_key_regs u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  // global advance: the output slot frees up or is already empty
  assign adv      = !vld_a[N] || out_ready;
  assign in_ready = adv;

  assign vld_a[0]   = in_valid;
  assign left_a[0]  = in_left_word;
  assign right_a[0] = in_right_word;

  for (genvar g = 0; g < N; g++) begin : g_stage
    tea_pkg::stage_ctl_t ctl;
    // even stage: left half-round; odd stage: right half-round of round g/2
    assign ctl.second = ((g % 2) == 1);
    assign ctl.total  = tea_pkg::round_total(g / 2);

    tea_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .ctl       (ctl),
      .keys      (keys),
      .vld_in    (vld_a[g]),
      .left_in   (left_a[g]),
      .right_in  (right_a[g]),
      .vld_out   (vld_a[g+1]),
      .left_out  (left_a[g+1]),
      .right_out (right_a[g+1])
    );
  end

  assign out_valid        = vld_a[N];
  assign out_cipher_left  = left_a[N];
  assign out_cipher_right = right_a[N];

  // an accepted item shows up in the first stage
  `TEA_ASSERT_NEXT(a_enter, in_valid && in_ready, vld_a[1], "accepted item not in stage 0")
  // a held result blocks intake
  `TEA_ASSERT_NOW(a_block, out_valid && !out_ready, !in_ready, "intake while output stalled")
  // a stall freezes valid bits inside the pipe
  `TEA_ASSERT_NEXT(a_freeze, !adv, (vld_a[1] == $past(vld_a[1])) &&
                   (vld_a[N-1] == $past(vld_a[N-1])), "pipeline moved during stall")

endmodule

### sim/tea_block_encrypt_tb.sv
// Self-checking testbench for tea_block_encrypt: TEA encryption of 64-bit blocks.
// Depends on tea_pkg and the tea_block_encrypt RTL; expected blocks computed in place.
`timescale 1ns / 1ps

module tea_block_encrypt_tb;

  typedef logic [tea_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  localparam int     CLK_HALF_NS    = 2;
  localparam int     RESET_CYCLES   = 10;
  localparam int     MAX_REPORTS    = 10;
  localparam int     DRAIN_CYCLES   = 2 * tea_pkg::STAGE_COUNT;  // wait after the last test for stray results
  localparam int     PHASE_BLOCKS   = 360;
  localparam int     HOLD_BLOCKS    = 110;
  localparam int     HOLD_CYCLES    = 400;
  localparam longint TIMEOUT_NS     = 2_000_000;

  // register indexes past the key words; writes to them must be dropped
  localparam cfg_idx_t KEY_IDX_BAD_LO = 8'd4;
  localparam cfg_idx_t KEY_IDX_BAD_HI = 8'hFF;

  typedef struct packed {
    tea_pkg::word_t left;
    tea_pkg::word_t right;
  } cipher_blk_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  tea_pkg::word_t       in_left_word     = '0;
  tea_pkg::word_t       in_right_word    = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  tea_pkg::word_t       out_cipher_left;
  tea_pkg::word_t       out_cipher_right;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index        = '0;
  tea_pkg::word_t       cfg_data         = '0;

  // testbench copy of the key registers, updated on each accepted write
  tea_pkg::key_set_t key_model;
  // cipher blocks owed by the DUT, oldest first
  cipher_blk_t       cipher_q[$];

  int send_idle_pct  = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;   // chance per cycle that out_ready is low
  int hold_left      = 0;   // cycles of forced output stall still to run
  int fail_count     = 0;
  int blocks_sent    = 0;
  int blocks_checked = 0;
  int key_settings   = 1;   // the reset key counts as the first

  tea_block_encrypt i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_left_word     (in_left_word),
    .in_right_word    (in_right_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_left  (out_cipher_left),
    .out_cipher_right (out_cipher_right),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout after %0d ns, %0d of %0d blocks checked",
             TIMEOUT_NS, blocks_checked, blocks_sent);
    $display("tea_block_encrypt_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Cipher prediction: 32 Feistel rounds, every sum wrapping at 32 bits since
  // all operands are word_t. The delta total steps before each round.
  // ---------------------------------------------------------------------------
  function automatic cipher_blk_t tea_encipher(input tea_pkg::word_t lw,
                                                input tea_pkg::word_t rw,
                                                input tea_pkg::key_set_t k);
    tea_pkg::word_t total;
    int             rnd;
    cipher_blk_t    blk;
    total = '0;
    for (rnd = 0; rnd < tea_pkg::ROUND_COUNT; rnd++) begin
      total = total + tea_pkg::TEA_DELTA;
      lw = lw + (((rw << 4) + k.k0) ^ (rw + total) ^ ((rw >> 5) + k.k1));
      rw = rw + (((lw << 4) + k.k2) ^ (lw + total) ^ ((lw >> 5) + k.k3));
    end
    blk.left  = lw;
    blk.right = rw;
    return blk;
  endfunction

  // Mostly uniform words, with a bias toward the edges and toward the
  // sign-extended characters that the log path feeds in.
  function automatic tea_pkg::word_t rand_word();
    logic [7:0] ch;
    ch = 8'($urandom);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return {{24{ch[7]}}, ch};
      default: return $urandom;
    endcase
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: sample at the edge, compare against the oldest expectation,
  // then pick out_ready for the next cycle. A forced hold wins over the
  // random stall.
  // ---------------------------------------------------------------------------
  initial begin
    cipher_blk_t exp_blk;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          note_failure($sformatf("unexpected cipher item %h %h",
                                 out_cipher_left, out_cipher_right));
        end else begin
          exp_blk = cipher_q.pop_front();
          blocks_checked++;
          if (out_cipher_left !== exp_blk.left)
            note_failure($sformatf("cipher_left: expected %h, got %h",
                                   exp_blk.left, out_cipher_left));
          if (out_cipher_right !== exp_blk.right)
            note_failure($sformatf("cipher_right: expected %h, got %h",
                                   exp_blk.right, out_cipher_right));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Plaintext side. Valid stays high across back-to-back items; it drops only when
  // the sender idles or stops offering, so no edge sees two writes to it.
  // ---------------------------------------------------------------------------
  task automatic send_block(input tea_pkg::word_t lw, input tea_pkg::word_t rw);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_left_word  <= lw;
    in_right_word <= rw;
    do @(posedge clk); while (!in_ready);
    // key is static within a phase, so the expectation can be formed here
    cipher_q.insert(cipher_q.size(), tea_encipher(lw, rw, key_model));
    blocks_sent++;
  endtask

  // Stop offering and wait until every owed cipher item has come out.
  // Each block yields exactly one result, so an empty queue means an
  // empty pipeline and the key may be rewritten safely.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  // One register write; valid is left high so writes can run back to back.
  task automatic cfg_write(input cfg_idx_t idx, input tea_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tea_pkg::KEY_IDX_0: key_model.k0 = data;
      tea_pkg::KEY_IDX_1: key_model.k1 = data;
      tea_pkg::KEY_IDX_2: key_model.k2 = data;
      tea_pkg::KEY_IDX_3: key_model.k3 = data;
      default: ;  // out of range: dropped by the DUT too
    endcase
  endtask

  task automatic load_key(input tea_pkg::key_set_t k);
    cfg_write(tea_pkg::KEY_IDX_0, k.k0);
    cfg_write(tea_pkg::KEY_IDX_1, k.k1);
    cfg_write(tea_pkg::KEY_IDX_2, k.k2);
    cfg_write(tea_pkg::KEY_IDX_3, k.k3);
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  task automatic load_random_key();
    tea_pkg::key_set_t k;
    k.k0 = rand_word();
    k.k1 = rand_word();
    k.k2 = rand_word();
    k.k3 = rand_word();
    load_key(k);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default key straight out of reset: plaintext edges, single set bits at
  // the word boundaries, and the log writer's char-plus-zero blocks.
  task automatic test_reset_key();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'h0000_0000, 32'hFFFF_FFFF);
    send_block(32'hFFFF_FFFF, 32'h0000_0000);
    send_block(32'h8000_0000, 32'h0000_0001);
    send_block(32'h0000_0001, 32'h8000_0000);
    send_block(32'hFFFF_FF80, 32'h0000_0000);
    send_block(32'h0000_0041, 32'h0000_0000);
    send_block(32'h0123_4567, 32'h89AB_CDEF);
    wait_drained();
  endtask

  // All-zero and all-ones keys, every register written.
  task automatic test_key_extremes();
    tea_pkg::key_set_t k;
    k = '0;
    load_key(k);
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'h0000_0000, 32'hFFFF_FFFF);
    send_block(32'hDEAD_BEEF, 32'h0000_0000);
    wait_drained();
    k = '1;
    load_key(k);
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'hFFFF_FFFF, 32'h0000_0000);
    send_block(32'h0000_0000, 32'hCAFE_F00D);
    wait_drained();
  endtask

  // Writes past the last key word must leave the key alone.
  task automatic test_ignored_index();
    cfg_write(KEY_IDX_BAD_LO, rand_word());
    cfg_write(KEY_IDX_BAD_HI, rand_word());
    cfg_write(cfg_idx_t'($urandom_range(KEY_IDX_BAD_LO, KEY_IDX_BAD_HI)), rand_word());
    cfg_valid <= 1'b0;
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'h1234_5678, 32'h0000_0000);
    send_block(32'h0000_0000, 32'h8765_4321);
    wait_drained();
  endtask

  // Random plaintext under a fresh random key with the given idling mix.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    load_random_key();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_BLOCKS) send_block(rand_word(), rand_word());
    wait_drained();
  endtask

  // Long output hold while the sender keeps offering: the pipeline fills,
  // in_ready must drop, and nothing may be lost or repeated once it resumes.
  task automatic test_output_hold();
    load_random_key();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    repeat (HOLD_BLOCKS) send_block(rand_word(), rand_word());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    key_model.k0 = tea_pkg::KEY0_RST;
    key_model.k1 = tea_pkg::KEY1_RST;
    key_model.k2 = tea_pkg::KEY2_RST;
    key_model.k3 = tea_pkg::KEY3_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_key();
    test_key_extremes();
    test_ignored_index();
    test_random_traffic(0, 0);
    test_random_traffic(87, 0);
    test_random_traffic(0, 87);
    test_random_traffic(32, 32);
    test_output_hold();

    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encrypted %0d blocks (%0d checked) under %0d key settings incl. reset,",
             blocks_sent, blocks_checked, key_settings);
    $display("zero and all-ones keys, dropped key writes, random idling, %0d-cycle hold.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tea_block_encrypt_tb OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("tea_block_encrypt_tb NOT OK");
    end
    $finish;
  end

endmodule
